>>> rtl/core/cpu16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu16_pkg
// Shared types and constants of the 16-bit execute unit.
// ----------------------------------------------------------------------------
package cpu16_pkg;

    localparam int RAM_BYTES = 4096;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int REG_COUNT = 16;

    localparam logic [4:0] OP_LD   = 5'd0;
    localparam logic [4:0] OP_LDR  = 5'd1;
    localparam logic [4:0] OP_LDE  = 5'd2;
    localparam logic [4:0] OP_LDM  = 5'd3;
    localparam logic [4:0] OP_ST   = 5'd4;
    localparam logic [4:0] OP_ADD  = 5'd5;
    localparam logic [4:0] OP_SUB  = 5'd6;
    localparam logic [4:0] OP_MUL  = 5'd7;
    localparam logic [4:0] OP_IMUL = 5'd8;
    localparam logic [4:0] OP_DIV  = 5'd9;
    localparam logic [4:0] OP_IDIV = 5'd10;
    localparam logic [4:0] OP_AND  = 5'd11;
    localparam logic [4:0] OP_OR   = 5'd12;
    localparam logic [4:0] OP_XOR  = 5'd13;
    localparam logic [4:0] OP_SHL  = 5'd14;
    localparam logic [4:0] OP_SHR  = 5'd15;
    localparam logic [4:0] OP_SAR  = 5'd16;
    localparam logic [4:0] OP_JMP  = 5'd17;
    localparam logic [4:0] OP_INT  = 5'd18;

    localparam logic [1:0] MODE_FULL = 2'd0;
    localparam logic [1:0] MODE_LOW  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [7:0] SEL_SAVED_PC = 8'd16;

    typedef struct packed {
        logic [4:0]  opcode;
        logic [7:0]  left_select;
        logic [7:0]  right_select;
        logic [15:0] immediate;
    } cpu16_in_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [15:0] written_value;
        logic        zero_flag;
        logic        sign_flag;
        logic        trap_taken;
    } cpu16_out_t;

    // divider handshake
    typedef struct packed {
        logic start;
        logic signed_op;
    } cpu16_div_ctl_t;

    typedef struct packed {
        logic done;
    } cpu16_div_sts_t;

    function automatic logic [15:0] merge16(logic [1:0] m, logic [15:0] old,
                                            logic [15:0] d);
        logic [15:0] r;
        unique case (m)
            MODE_FULL: r = d;
            MODE_LOW:  r = {old[15:8], d[7:0]};
            MODE_HIGH: r = {d[15:8], old[7:0]};
            default:   r = old;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] view16(logic [1:0] m, logic [15:0] v);
        logic [15:0] r;
        unique case (m)
            MODE_FULL: r = v;
            MODE_LOW:  r = {8'h00, v[7:0]};
            MODE_HIGH: r = {8'h00, v[15:8]};
            default:   r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/cpu16_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu16_execute_unit
// Executes one instruction of a 16-bit machine per input item.
// ----------------------------------------------------------------------------
// States from acceptance to result: register ops READ, EXEC, OUT; RAM loads
// add MRD1, MRD2; stores MRD1, MRD2, MWR; divides DIVW (16 divider steps), DIVR;
// divide by zero traps like a register op. One item at a time; s_ready is low
// from acceptance until the result is taken, then rises the next cycle.
// After reset all 4096 RAM bytes are cleared, one byte per cycle, while
// s_ready stays low. Configuration writes are accepted at any time.
module cpu16_execute_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cpu16_pkg::cpu16_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cpu16_pkg::cpu16_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);

    localparam int RAM_AW_L = cpu16_pkg::RAM_AW;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_EXEC  = 4'd3;
    localparam logic [3:0] ST_MRD1  = 4'd4;
    localparam logic [3:0] ST_MRD2  = 4'd5;
    localparam logic [3:0] ST_MWR   = 4'd6;
    localparam logic [3:0] ST_DIVW  = 4'd7;
    localparam logic [3:0] ST_DIVR  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [RAM_AW_L-1:0] clr_reg;

    logic [15:0] rf_reg [cpu16_pkg::REG_COUNT];
    logic [15:0] spc_reg, pc_reg, vec_reg;
    logic        zf_reg, sf_reg, if_reg;
    cpu16_pkg::cpu16_in_t  ins_reg;
    cpu16_pkg::cpu16_out_t out_reg;
    logic [15:0] a_reg, b_reg, rawr_reg, word_reg;
    logic [7:0]  lo_reg;

    logic [7:0] ram [cpu16_pkg::RAM_BYTES];
    logic [7:0] ram_q_reg;
    logic       ram_we;
    logic [RAM_AW_L-1:0] ram_addr;
    logic [7:0] ram_wd;

    cpu16_pkg::cpu16_div_ctl_t div_ctl;
    cpu16_pkg::cpu16_div_sts_t div_sts;
    logic [15:0] div_q, div_r;

    logic [1:0]  lmode, rmode;
    logic [15:0] lraw, rraw;
    logic [15:0] res;
    logic        res_sf;
    logic [15:0] mul_p;
    logic [15:0] st_word;
    logic [RAM_AW_L-1:0] addr0, addr1;

    function automatic logic [15:0] reg_rd(logic [7:0] sel, logic [15:0] rfv,
                                           logic [15:0] spc);
        return (sel == cpu16_pkg::SEL_SAVED_PC) ? spc : rfv;
    endfunction

    assign lmode = ins_reg.left_select[5:4];
    assign rmode = ins_reg.right_select[5:4];
    assign lraw  = reg_rd(ins_reg.left_select, rf_reg[ins_reg.left_select[3:0]], spc_reg);
    assign rraw  = reg_rd(ins_reg.right_select, rf_reg[ins_reg.right_select[3:0]], spc_reg);
    assign addr0 = ins_reg.immediate[RAM_AW_L-1:0];
    assign addr1 = RAM_AW_L'(ins_reg.immediate + 16'd1);
    assign mul_p = a_reg * b_reg;
    // store word: old RAM word with the selected bytes of the raw register
    assign st_word = cpu16_pkg::merge16(rmode, word_reg, rawr_reg);

    assign div_ctl.start     = (state_reg == ST_EXEC) &&
                               (ins_reg.opcode == cpu16_pkg::OP_DIV ||
                                ins_reg.opcode == cpu16_pkg::OP_IDIV) &&
                               (b_reg != 16'd0);
    assign div_ctl.signed_op = (ins_reg.opcode == cpu16_pkg::OP_IDIV);

    cpu16_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .sts       (div_sts),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // ALU result
    always_comb begin
        res    = 16'd0;
        res_sf = 1'b0;
        unique case (ins_reg.opcode)
            cpu16_pkg::OP_ADD: res = a_reg + b_reg;
            cpu16_pkg::OP_SUB: begin
                res    = a_reg - b_reg;
                res_sf = a_reg < b_reg;
            end
            cpu16_pkg::OP_MUL: res = mul_p;
            cpu16_pkg::OP_IMUL: begin
                res    = mul_p;
                res_sf = mul_p[15];
            end
            cpu16_pkg::OP_AND: res = a_reg & b_reg;
            cpu16_pkg::OP_OR:  res = a_reg | b_reg;
            cpu16_pkg::OP_XOR: res = a_reg ^ b_reg;
            cpu16_pkg::OP_SHL: res = (b_reg >= 16'd16) ? 16'd0 : a_reg << b_reg[3:0];
            cpu16_pkg::OP_SHR: res = (b_reg >= 16'd16) ? 16'd0 : a_reg >> b_reg[3:0];
            cpu16_pkg::OP_SAR: begin
                res = $signed(a_reg) >>> ((b_reg >= 16'd16) ? 4'd15 : b_reg[3:0]);
                res_sf = res[15];
            end
            default: res = 16'd0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_addr   = addr0;
        ram_wd     = 8'd0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                if (clr_reg == '1) state_next = ST_IDLE;
            end
            ST_IDLE: if (s_valid) state_next = ST_READ;
            ST_READ: begin
                if (ins_reg.opcode == cpu16_pkg::OP_LDM ||
                    ins_reg.opcode == cpu16_pkg::OP_ST) state_next = ST_MRD1;
                else state_next = ST_EXEC;
            end
            ST_MRD1: begin
                ram_addr   = addr1;
                state_next = ST_MRD2;
            end
            ST_MRD2: state_next = (ins_reg.opcode == cpu16_pkg::OP_ST) ? ST_MWR : ST_EXEC;
            ST_MWR: begin
                ram_we     = (rmode != cpu16_pkg::MODE_NONE);
                ram_addr   = addr1;
                ram_wd     = st_word[15:8];
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (ins_reg.opcode == cpu16_pkg::OP_ST) begin
                    ram_we = (rmode != cpu16_pkg::MODE_NONE);
                    ram_wd = st_word[7:0];
                end
                state_next = div_ctl.start ? ST_DIVW : ST_OUT;
            end
            ST_DIVW: if (div_sts.done) state_next = ST_DIVR;
            ST_DIVR: state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ram_we) ram[ram_addr] <= ram_wd;
        ram_q_reg <= ram[ram_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            for (int i = 0; i < cpu16_pkg::REG_COUNT; i++) rf_reg[i] <= 16'd0;
            spc_reg <= 16'd0;
            pc_reg  <= 16'd0;
            vec_reg <= 16'd0;
            zf_reg  <= 1'b0;
            sf_reg  <= 1'b0;
            if_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) vec_reg <= cfg_data;
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE:  if (s_valid) ins_reg <= s_data;
                ST_READ: begin
                    a_reg    <= cpu16_pkg::view16(lmode, lraw);
                    b_reg    <= cpu16_pkg::view16(rmode, rraw);
                    rawr_reg <= rraw;
                    out_reg  <= '0;
                end
                ST_EXEC: begin
                    unique case (ins_reg.opcode)
                        cpu16_pkg::OP_LD, cpu16_pkg::OP_LDM: begin
                            logic [15:0] d, nv;
                            d  = (ins_reg.opcode == cpu16_pkg::OP_LD) ? ins_reg.immediate
                                 : word_reg;
                            nv = cpu16_pkg::merge16(rmode, rraw, d);
                            if (rmode != cpu16_pkg::MODE_NONE) begin
                                if (ins_reg.right_select == cpu16_pkg::SEL_SAVED_PC) spc_reg <= nv;
                                else rf_reg[ins_reg.right_select[3:0]] <= nv;
                                out_reg.written_value <= nv;
                            end
                            pc_reg <= pc_reg + 16'd3;
                            out_reg.next_pc <= pc_reg + 16'd3;
                        end
                        cpu16_pkg::OP_LDR, cpu16_pkg::OP_LDE: begin
                            logic [15:0] d, nv;
                            d  = (ins_reg.opcode == cpu16_pkg::OP_LDR) ? rawr_reg
                                 : rf_reg[rawr_reg[3:0]];
                            nv = cpu16_pkg::merge16(lmode, lraw, d);
                            if (lmode != cpu16_pkg::MODE_NONE) begin
                                if (ins_reg.left_select == cpu16_pkg::SEL_SAVED_PC) spc_reg <= nv;
                                else rf_reg[ins_reg.left_select[3:0]] <= nv;
                                out_reg.written_value <= nv;
                            end
                            pc_reg <= pc_reg + 16'd2;
                            out_reg.next_pc <= pc_reg + 16'd2;
                        end
                        cpu16_pkg::OP_ST: begin
                            if (rmode != cpu16_pkg::MODE_NONE) out_reg.written_value <= st_word;
                            pc_reg <= pc_reg + 16'd3;
                            out_reg.next_pc <= pc_reg + 16'd3;
                        end
                        cpu16_pkg::OP_DIV, cpu16_pkg::OP_IDIV: begin
                            if (b_reg == 16'd0) begin
                                spc_reg <= pc_reg + 16'd2;
                                pc_reg  <= vec_reg;
                                if_reg  <= 1'b1;
                                out_reg.next_pc    <= vec_reg;
                                out_reg.trap_taken <= 1'b1;
                            end else begin
                                pc_reg <= pc_reg + 16'd2;
                                out_reg.next_pc <= pc_reg + 16'd2;
                            end
                        end
                        cpu16_pkg::OP_JMP: begin
                            pc_reg <= ins_reg.immediate;
                            out_reg.next_pc <= ins_reg.immediate;
                        end
                        cpu16_pkg::OP_INT: begin
                            spc_reg <= pc_reg;
                            pc_reg  <= ins_reg.immediate;
                            if_reg  <= 1'b1;
                            out_reg.next_pc    <= ins_reg.immediate;
                            out_reg.trap_taken <= 1'b1;
                        end
                        cpu16_pkg::OP_ADD, cpu16_pkg::OP_SUB, cpu16_pkg::OP_MUL,
                        cpu16_pkg::OP_IMUL, cpu16_pkg::OP_AND, cpu16_pkg::OP_OR,
                        cpu16_pkg::OP_XOR, cpu16_pkg::OP_SHL, cpu16_pkg::OP_SHR,
                        cpu16_pkg::OP_SAR: begin
                            logic [15:0] d, nv;
                            d  = res;
                            nv = cpu16_pkg::merge16(lmode, lraw, d);
                            if (lmode != cpu16_pkg::MODE_NONE) begin
                                if (ins_reg.left_select == cpu16_pkg::SEL_SAVED_PC) spc_reg <= nv;
                                else rf_reg[ins_reg.left_select[3:0]] <= nv;
                                out_reg.written_value <= nv;
                            end
                            zf_reg <= (res == 16'd0);
                            sf_reg <= res_sf;
                            pc_reg <= pc_reg + 16'd2;
                            out_reg.next_pc <= pc_reg + 16'd2;
                        end
                        default: out_reg.next_pc <= pc_reg;
                    endcase
                end
                ST_DIVR: begin
                    logic [15:0] ql, rr, lnew;
                    logic        same;
                    same = (ins_reg.left_select == cpu16_pkg::SEL_SAVED_PC) ==
                           (ins_reg.right_select == cpu16_pkg::SEL_SAVED_PC) &&
                           ((ins_reg.left_select == cpu16_pkg::SEL_SAVED_PC) ||
                            ins_reg.left_select[3:0] == ins_reg.right_select[3:0]);
                    ql   = cpu16_pkg::merge16(lmode, lraw, div_q);
                    rr   = cpu16_pkg::merge16(rmode, same ? ql : rraw, div_r);
                    lnew = same ? rr : ql;
                    // one register on both sides: the remainder lands last
                    if (same) begin
                        if (ins_reg.left_select == cpu16_pkg::SEL_SAVED_PC) spc_reg <= rr;
                        else rf_reg[ins_reg.left_select[3:0]] <= rr;
                    end else begin
                        if (ins_reg.left_select == cpu16_pkg::SEL_SAVED_PC) spc_reg <= ql;
                        else rf_reg[ins_reg.left_select[3:0]] <= ql;
                        if (ins_reg.right_select == cpu16_pkg::SEL_SAVED_PC) spc_reg <= rr;
                        else rf_reg[ins_reg.right_select[3:0]] <= rr;
                    end
                    out_reg.written_value <= (lmode != cpu16_pkg::MODE_NONE) ? lnew : 16'd0;
                    zf_reg <= (div_q == 16'd0);
                    sf_reg <= div_ctl.signed_op & div_q[15];
                end
                default: ;
            endcase
        end
    end

    // RAM word assembly: byte a is here in MRD1, byte a+1 in MRD2.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_MRD1) lo_reg <= ram_q_reg;
        if (state_reg == ST_MRD2) word_reg <= {ram_q_reg, lo_reg};
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign m_data    = '{next_pc: out_reg.next_pc, written_value: out_reg.written_value,
                         zero_flag: zf_reg, sign_flag: sf_reg,
                         trap_taken: out_reg.trap_taken};

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and output active together");
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_ctl.start |=> state_reg == ST_DIVW) else $error("divider start lost");
    a_trap_if: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.trap_taken) |-> if_reg) else $error("trap without IF");

endmodule

>>> rtl/core/cpu16_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu16_div
// Radix-2 restoring divider, one quotient bit per cycle, signed or unsigned.
// ----------------------------------------------------------------------------
module cpu16_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cpu16_pkg::cpu16_div_ctl_t ctl,
    input  logic [15:0]               dividend,
    input  logic [15:0]               divisor,
    output cpu16_pkg::cpu16_div_sts_t sts,
    output logic [15:0]               quotient,
    output logic [15:0]               remainder
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [15:0] abs_a, abs_b;

    assign abs_a = (ctl.signed_op && dividend[15]) ? 16'(-dividend) : dividend;
    assign abs_b = (ctl.signed_op && divisor[15]) ? 16'(-divisor) : divisor;
    assign trial = {r_reg[15:0], q_reg[15]} - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            q_next    = abs_a;
            r_next    = 17'd0;
            d_next    = abs_b;
            negq_next = ctl.signed_op && (dividend[15] ^ divisor[15]);
            negr_next = ctl.signed_op && dividend[15];
        end else if (busy_reg) begin
            // shift one bit in, keep the trial difference if it fits
            if (!trial[16]) begin
                r_next = trial;
                q_next = {q_reg[14:0], 1'b1};
            end else begin
                r_next = {r_reg[15:0], q_reg[15]};
                q_next = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign sts.done  = done_reg;
    assign quotient  = negq_reg ? 16'(-q_reg) : q_reg;
    assign remainder = negr_reg ? 16'(-r_reg[15:0]) : r_reg[15:0];

endmodule

>>> tb/tb_cpu16_execute_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu16_execute_unit
// Drives instructions into the execute unit with random gaps on both sides
// and checks each result against a behavioral model of the machine state.
// ----------------------------------------------------------------------------
module tb_cpu16_execute_unit;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAM_BYTES    = cpu16_pkg::RAM_BYTES;
    localparam int REG_COUNT    = cpu16_pkg::REG_COUNT;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    cpu16_pkg::cpu16_in_t  s_data;
    logic                  m_valid;
    logic                  m_ready;
    cpu16_pkg::cpu16_out_t m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [15:0]           cfg_data;

    cpu16_execute_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // machine state mirror
    logic [15:0] gpr [REG_COUNT];
    logic [15:0] pb_reg;
    logic [15:0] pc_reg;
    logic        zf;
    logic        sf;
    logic [7:0]  ram [RAM_BYTES];
    logic [15:0] trap_vector;

    cpu16_pkg::cpu16_out_t pending_results [$];
    int          error_count;
    int          cycle_count = 0;
    bit          hold_off_long;

    typedef struct {
        logic [4:0]  op;
        logic [7:0]  ls;
        logic [7:0]  rs;
        logic [15:0] imm;
        bit          known;
        cpu16_pkg::cpu16_out_t res;
    } directed_row_t;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** cpu16_execute_unit: FAILED **");
            $finish;
        end
    end

    function automatic logic [1:0] mode_of(logic [7:0] sel);
        return sel[5:4];
    endfunction

    function automatic logic [15:0] reg_value(logic [7:0] sel);
        if (sel == cpu16_pkg::SEL_SAVED_PC) return pb_reg;
        return gpr[sel[3:0]];
    endfunction

    function automatic logic [15:0] read_view(logic [7:0] sel);
        logic [15:0] v;
        v = reg_value(sel);
        case (mode_of(sel))
            cpu16_pkg::MODE_FULL: return v;
            cpu16_pkg::MODE_LOW:  return {8'h00, v[7:0]};
            cpu16_pkg::MODE_HIGH: return {8'h00, v[15:8]};
            default:              return 16'h0000;
        endcase
    endfunction

    function automatic logic [15:0] blend(logic [1:0] m, logic [15:0] old,
                                          logic [15:0] d);
        case (m)
            cpu16_pkg::MODE_FULL: return d;
            cpu16_pkg::MODE_LOW:  return {old[15:8], d[7:0]};
            cpu16_pkg::MODE_HIGH: return {d[15:8], old[7:0]};
            default:              return old;
        endcase
    endfunction

    function automatic logic [15:0] write_reg(logic [7:0] sel, logic [15:0] d);
        logic [15:0] nv;
        if (mode_of(sel) == cpu16_pkg::MODE_NONE) return 16'h0000;
        nv = blend(mode_of(sel), reg_value(sel), d);
        if (sel == cpu16_pkg::SEL_SAVED_PC) pb_reg = nv;
        else gpr[sel[3:0]] = nv;
        return nv;
    endfunction

    function automatic logic [15:0] ram_word(logic [15:0] a);
        return {ram[(a + 1) % RAM_BYTES], ram[a % RAM_BYTES]};
    endfunction

    function automatic void reset_machine();
        for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
        for (int i = 0; i < RAM_BYTES; i++) ram[i] = '0;
        pb_reg = '0;
        pc_reg = '0;
        zf = 1'b0;
        sf = 1'b0;
        trap_vector = '0;
    endfunction

    function automatic cpu16_pkg::cpu16_out_t execute(cpu16_pkg::cpu16_in_t it);
        cpu16_pkg::cpu16_out_t o;
        logic [15:0] a, b, v, res, q, rem, nw;
        logic        sflag, trap;
        int          sa, sb, sh;
        logic [31:0] prod;
        a = '0; b = '0; v = '0; res = '0; q = '0; rem = '0; nw = '0;
        sflag = 1'b0; trap = 1'b0; sa = 0; sb = 0; sh = 0; prod = '0;
        o = '0;
        case (it.opcode)
            cpu16_pkg::OP_LD: begin
                o.written_value = write_reg(it.right_select, it.immediate);
                pc_reg = pc_reg + 16'd3;
            end
            cpu16_pkg::OP_LDR, cpu16_pkg::OP_LDE: begin
                v = reg_value(it.right_select);
                if (it.opcode == cpu16_pkg::OP_LDE) v = gpr[v[3:0]];
                o.written_value = write_reg(it.left_select, v);
                pc_reg = pc_reg + 16'd2;
            end
            cpu16_pkg::OP_LDM: begin
                o.written_value = write_reg(it.right_select, ram_word(it.immediate));
                pc_reg = pc_reg + 16'd3;
            end
            cpu16_pkg::OP_ST: begin
                if (mode_of(it.right_select) != cpu16_pkg::MODE_NONE) begin
                    nw = blend(mode_of(it.right_select), ram_word(it.immediate),
                               reg_value(it.right_select));
                    ram[it.immediate % RAM_BYTES] = nw[7:0];
                    ram[(it.immediate + 1) % RAM_BYTES] = nw[15:8];
                    o.written_value = nw;
                end
                pc_reg = pc_reg + 16'd3;
            end
            cpu16_pkg::OP_DIV, cpu16_pkg::OP_IDIV: begin
                a = read_view(it.left_select);
                b = read_view(it.right_select);
                pc_reg = pc_reg + 16'd2;
                if (b == 16'd0) begin
                    pb_reg = pc_reg;
                    pc_reg = trap_vector;
                    trap = 1'b1;
                end else begin
                    if (it.opcode == cpu16_pkg::OP_DIV) begin
                        q = a / b;
                        rem = a % b;
                    end else begin
                        sa = $signed(a);
                        sb = $signed(b);
                        q = 16'(sa / sb);
                        rem = 16'(sa % sb);
                    end
                    void'(write_reg(it.left_select, q));
                    void'(write_reg(it.right_select, rem));
                    o.written_value = (mode_of(it.left_select) != cpu16_pkg::MODE_NONE) ?
                                      reg_value(it.left_select) : 16'h0000;
                    zf = (q == 16'd0);
                    sf = (it.opcode == cpu16_pkg::OP_IDIV) ? q[15] : 1'b0;
                end
            end
            cpu16_pkg::OP_ADD, cpu16_pkg::OP_SUB, cpu16_pkg::OP_MUL, cpu16_pkg::OP_IMUL,
            cpu16_pkg::OP_AND, cpu16_pkg::OP_OR, cpu16_pkg::OP_XOR,
            cpu16_pkg::OP_SHL, cpu16_pkg::OP_SHR, cpu16_pkg::OP_SAR: begin
                a = read_view(it.left_select);
                b = read_view(it.right_select);
                prod = a * b;
                case (it.opcode)
                    cpu16_pkg::OP_ADD:  res = a + b;
                    cpu16_pkg::OP_SUB:  begin res = a - b; sflag = (a < b); end
                    cpu16_pkg::OP_MUL:  res = prod[15:0];
                    cpu16_pkg::OP_IMUL: begin res = prod[15:0]; sflag = res[15]; end
                    cpu16_pkg::OP_AND:  res = a & b;
                    cpu16_pkg::OP_OR:   res = a | b;
                    cpu16_pkg::OP_XOR:  res = a ^ b;
                    cpu16_pkg::OP_SHL:  res = (b >= 16'd16) ? 16'h0 : (a << b[3:0]);
                    cpu16_pkg::OP_SHR:  res = (b >= 16'd16) ? 16'h0 : (a >> b[3:0]);
                    default: begin
                        sh = (b >= 16'd16) ? 15 : int'(b);
                        res = $signed(a) >>> sh;
                        sflag = res[15];
                    end
                endcase
                o.written_value = write_reg(it.left_select, res);
                zf = (res == 16'd0);
                sf = sflag;
                pc_reg = pc_reg + 16'd2;
            end
            cpu16_pkg::OP_JMP: pc_reg = it.immediate;
            cpu16_pkg::OP_INT: begin
                pb_reg = pc_reg;
                pc_reg = it.immediate;
                trap = 1'b1;
            end
            default: ;
        endcase
        o.next_pc = pc_reg;
        o.zero_flag = zf;
        o.sign_flag = sf;
        o.trap_taken = trap;
        return o;
    endfunction

    // result side: random stall, with one long hold-off on request
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_off_long) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off_long = 0;
            end
            gap = ($urandom_range(0, 9) < 6) ? 0 :
                  (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) :
                   $urandom_range(20, 60));
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cpu16_pkg::cpu16_out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result next_pc=%h", m_data.next_pc);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.next_pc !== exp_r.next_pc) begin
                    $error("next_pc exp %h got %h", exp_r.next_pc, m_data.next_pc);
                    error_count++;
                end
                if (m_data.written_value !== exp_r.written_value) begin
                    $error("written_value exp %h got %h", exp_r.written_value,
                           m_data.written_value);
                    error_count++;
                end
                if (m_data.zero_flag !== exp_r.zero_flag) begin
                    $error("zero_flag exp %b got %b", exp_r.zero_flag, m_data.zero_flag);
                    error_count++;
                end
                if (m_data.sign_flag !== exp_r.sign_flag) begin
                    $error("sign_flag exp %b got %b", exp_r.sign_flag, m_data.sign_flag);
                    error_count++;
                end
                if (m_data.trap_taken !== exp_r.trap_taken) begin
                    $error("trap_taken exp %b got %b", exp_r.trap_taken,
                           m_data.trap_taken);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(cpu16_pkg::cpu16_in_t it, bit known,
                             cpu16_pkg::cpu16_out_t res);
        cpu16_pkg::cpu16_out_t p;
        int gap;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) :
               $urandom_range(15, 50));
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        p = execute(it);
        if (known && p !== res) begin
            $error("table row disagrees with model: exp %h model %h", res, p);
            error_count++;
        end
        pending_results.push_back(p);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_vector(logic [15:0] v);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        trap_vector = v;
    endtask

    function automatic logic [7:0] rand_sel();
        logic [7:0] s;
        s = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 7) s[7:6] = 2'b00;
        if ($urandom_range(0, 19) == 0) s = cpu16_pkg::SEL_SAVED_PC;
        return s;
    endfunction

    function automatic cpu16_pkg::cpu16_in_t rand_item();
        cpu16_pkg::cpu16_in_t it;
        it.opcode = ($urandom_range(0, 49) == 0) ? 5'($urandom_range(19, 31)) :
                    5'($urandom_range(0, 18));
        it.left_select  = rand_sel();
        it.right_select = rand_sel();
        case ($urandom_range(0, 5))
            0: it.immediate = 16'h0000;
            1: it.immediate = 16'hffff;
            2: it.immediate = 16'($urandom_range(0, 31));
            default: it.immediate = 16'($urandom_range(0, 65535));
        endcase
        return it;
    endfunction

    function automatic cpu16_pkg::cpu16_out_t mk(logic [15:0] pc, logic [15:0] wv,
                                                 logic z, logic s, logic t);
        cpu16_pkg::cpu16_out_t o;
        o.next_pc = pc; o.written_value = wv;
        o.zero_flag = z; o.sign_flag = s; o.trap_taken = t;
        return o;
    endfunction

    initial begin
        directed_row_t rows [$];
        directed_row_t row;
        cpu16_pkg::cpu16_in_t it;
        error_count = 0;
        hold_off_long = 0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        reset_machine();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // known rows read off the reset state; the rest use the model
        rows.push_back('{cpu16_pkg::OP_LD, 8'h00, 8'h00, 16'hffff, 1,
                         mk(16'd3, 16'hffff, 0, 0, 0)});
        rows.push_back('{cpu16_pkg::OP_LD, 8'h00, 8'h11, 16'h0000, 1,
                         mk(16'd6, 16'h0000, 0, 0, 0)});
        rows.push_back('{cpu16_pkg::OP_LD, 8'h00, 8'h22, 16'h8000, 0, '0});
        rows.push_back('{cpu16_pkg::OP_LD, 8'h00, 8'h33, 16'h1234, 0, '0});
        rows.push_back('{cpu16_pkg::OP_LD, 8'h00, 8'h03, 16'hffff, 0, '0});
        rows.push_back('{cpu16_pkg::OP_DIV, 8'h00, 8'h04, 16'h0000, 1,
                         mk(16'h0000, 16'h0, 0, 0, 1)});
        rows.push_back('{cpu16_pkg::OP_LDR, 8'h05, 8'h00, 16'h0000, 0, '0});
        rows.push_back('{cpu16_pkg::OP_LDE, 8'h06, 8'h02, 16'h0000, 0, '0});
        rows.push_back('{cpu16_pkg::OP_LDR, 8'h16, cpu16_pkg::SEL_SAVED_PC, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_ST, 8'h00, 8'h00, 16'hffff, 0, '0});
        rows.push_back('{cpu16_pkg::OP_ST, 8'h00, 8'h20, 16'h0100, 0, '0});
        rows.push_back('{cpu16_pkg::OP_LDM, 8'h00, 8'h07, 16'hffff, 0, '0});
        rows.push_back('{cpu16_pkg::OP_SUB, 8'h04, 8'h00, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_ADD, 8'h00, 8'h00, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_IMUL, 8'h00, 8'h00, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_MUL, 8'h05, 8'h05, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_LD, 8'h00, 8'h08, 16'h8000, 0, '0});
        rows.push_back('{cpu16_pkg::OP_LD, 8'h00, 8'h09, 16'hffff, 0, '0});
        rows.push_back('{cpu16_pkg::OP_IDIV, 8'h08, 8'h09, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_IDIV, 8'h03, 8'h03, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_SAR, 8'h09, 8'h03, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_SHL, 8'h03, 8'h00, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_AND, 8'h03, 8'h11, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_INT, 8'h00, 8'h00, 16'hfffe, 0, '0});
        rows.push_back('{5'd31, 8'h00, 8'h00, 16'h0, 0, '0});
        rows.push_back('{cpu16_pkg::OP_JMP, 8'h00, 8'h00, 16'h0000, 0, '0});
        foreach (rows[i]) begin
            row = rows[i];
            it.opcode = row.op; it.left_select = row.ls;
            it.right_select = row.rs; it.immediate = row.imm;
            send_item(it, row.known, row.res);
        end

        write_vector(16'hffff);
        for (int k = 0; k < 1850; k++) begin
            if (k == 400) hold_off_long = 1;
            if (k == 600) write_vector(16'h0000);
            if (k == 1000) begin
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            if (k == 1200) write_vector(16'($urandom_range(0, 65535)));
            if (k == 1600) write_vector(16'h8001);
            send_item(rand_item(), 0, '0);
        end
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("** cpu16_execute_unit: PASSED **");
        end else begin
            $display("** cpu16_execute_unit: FAILED **");
        end
        $finish;
    end
endmodule
